FILE: rtl/core/wht_pkg.sv
// Package for the water heater thermostat: widths, limits, event codes, sample conversion.
package wht_pkg;

	localparam int OPC_W    = 2;
	localparam int ADC_W    = 10;
	localparam int SET_W    = 7;
	localparam int TEMP_W   = 8;
	localparam int SUM_W    = 12;
	localparam int PROD_W   = 25;
	localparam int Q_SHIFT  = 16;

	localparam int WINDOW_DEF = 10;

	localparam logic [SET_W-1:0] SET_MIN  = 7'd35;
	localparam logic [SET_W-1:0] SET_MAX  = 7'd75;
	localparam logic [SET_W-1:0] SET_STEP = 7'd5;
	localparam logic [SET_W-1:0] SET_INIT = 7'd60;

	// 0.4902 and 0.2944 in Q16
	localparam logic [14:0]       GAIN_Q16   = 15'd32126;
	localparam logic [PROD_W-1:0] OFFSET_Q16 = 25'd19294;

	typedef enum logic [OPC_W-1:0] {
		OP_DOWN   = 2'd0,
		OP_UP     = 2'd1,
		OP_TOGGLE = 2'd2,
		OP_SAMPLE = 2'd3
	} op_t;

	// ADC code to degrees, clamped to 0..255
	function automatic logic [TEMP_W-1:0] to_degrees(input logic [ADC_W-1:0] adc);
		logic [PROD_W-1:0]         p;
		logic [PROD_W-Q_SHIFT-1:0] t;
		p = PROD_W'(adc) * PROD_W'(GAIN_Q16);
		t = '0;
		if (p >= OFFSET_Q16) begin
			t = (PROD_W-Q_SHIFT)'((p - OFFSET_Q16) >> Q_SHIFT);
		end
		if (p < OFFSET_Q16) begin
			return '0;
		end else if (t > (PROD_W-Q_SHIFT)'(255)) begin
			return '1;
		end else begin
			return t[TEMP_W-1:0];
		end
	endfunction

endpackage

FILE: rtl/core/water_heater_thermostat.sv
// Water heater thermostat: event-driven bang-bang regulator with a moving-average temperature.
//
// Every accepted item (down, up, power toggle or ADC sample) gives exactly one status item.
// An item is taken each cycle while the result side is free; its status item passes through
// the input register, which loads at the accepting edge (the ADC code is converted to degrees
// on the way in), and then the result register, where the setpoint, ring and mean are updated
// and which loads once the result side is free. The mean is refreshed when the last of the
// WINDOW ring slots is written, as the ring sum divided by WINDOW (a reciprocal multiply).
// Backpressure on the result side stalls both stages.
module water_heater_thermostat #(
	parameter int WINDOW = wht_pkg::WINDOW_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [wht_pkg::OPC_W-1:0]   opcode,
	input  logic [wht_pkg::ADC_W-1:0]   adc_sample,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic                        heater_on,
	output logic                        cooler_on,
	output logic                        display_on,
	output logic [wht_pkg::SET_W-1:0]   display_value,
	output logic [wht_pkg::TEMP_W-1:0]  mean_temperature,
	output logic                        is_running
);
	import wht_pkg::*;

	localparam int IDX_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int DIV_SHIFT = SUM_W + IDX_W;
	localparam int DIV_MUL   = ((1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
	localparam int DPROD_W   = SUM_W + DIV_SHIFT + 1;

	localparam logic [DIV_SHIFT:0] DIV_MUL_C = (DIV_SHIFT+1)'(DIV_MUL);
	localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(WINDOW - 1);
	localparam logic [SUM_W-1:0]   SUM_INIT  = SUM_W'(WINDOW * 60);

	// input stage
	logic              valid_s1;
	op_t               opcode_s1;
	logic [TEMP_W-1:0] temp_s1;

	// state
	logic              running_q;
	logic [SET_W-1:0]  setpoint_q;
	logic [SET_W-1:0]  latched_q;
	logic [TEMP_W-1:0] ring_q [WINDOW];
	logic [IDX_W-1:0]  idx_q;
	logic [SUM_W-1:0]  sum_q;
	logic [TEMP_W-1:0] mean_q;

	// result register
	logic              result_valid_q;
	logic              heater_q;
	logic              cooler_q;
	logic              display_q;
	logic [SET_W-1:0]  display_value_q;
	logic [TEMP_W-1:0] mean_out_q;
	logic              running_out_q;

	// next state
	logic              running_d;
	logic [SET_W-1:0]  setpoint_d;
	logic [SET_W-1:0]  latched_d;
	logic [IDX_W-1:0]  idx_d;
	logic [SUM_W-1:0]  sum_d;
	logic [TEMP_W-1:0] mean_d;
	logic [DPROD_W-1:0] div_prod;

	logic out_free;
	logic advance;
	logic take;

	assign out_free   = !result_valid_q || result_ready;
	assign advance    = valid_s1 && out_free;
	assign item_ready = !valid_s1 || out_free;
	assign take       = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			opcode_s1 <= op_t'(opcode);
			temp_s1   <= to_degrees(adc_sample);
		end
	end

	always_comb begin
		running_d  = running_q;
		setpoint_d = setpoint_q;
		latched_d  = latched_q;
		idx_d      = idx_q;
		sum_d      = sum_q;
		mean_d     = mean_q;
		div_prod   = '0;
		unique case (opcode_s1)
			OP_DOWN: begin
				if (setpoint_q > SET_MIN) begin
					setpoint_d = setpoint_q - SET_STEP;
				end
			end
			OP_UP: begin
				if (setpoint_q < SET_MAX) begin
					setpoint_d = setpoint_q + SET_STEP;
				end
			end
			OP_TOGGLE: begin
				running_d = !running_q;
				if (!running_q) begin
					latched_d = setpoint_q;
				end
			end
			OP_SAMPLE: begin
				sum_d    = sum_q - SUM_W'(ring_q[idx_q]) + SUM_W'(temp_s1);
				div_prod = DPROD_W'(sum_d) * DPROD_W'(DIV_MUL_C);
				if (idx_q == IDX_LAST) begin
					mean_d = div_prod[DIV_SHIFT +: TEMP_W];
					idx_d  = '0;
				end else begin
					idx_d  = idx_q + IDX_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			setpoint_q <= SET_INIT;
			latched_q  <= SET_INIT;
			idx_q      <= '0;
			sum_q      <= SUM_INIT;
			mean_q     <= '0;
			for (int k = 0; k < WINDOW; k++) begin
				ring_q[k] <= TEMP_W'(SET_INIT);
			end
		end else if (advance) begin
			running_q  <= running_d;
			setpoint_q <= setpoint_d;
			latched_q  <= latched_d;
			idx_q      <= idx_d;
			sum_q      <= sum_d;
			mean_q     <= mean_d;
			if (opcode_s1 == OP_SAMPLE) begin
				ring_q[idx_q] <= temp_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			heater_q        <= running_d && (TEMP_W'(latched_d) > mean_d);
			cooler_q        <= running_d && (TEMP_W'(latched_d) < mean_d);
			display_q       <= !running_d;
			display_value_q <= setpoint_d;
			mean_out_q      <= mean_d;
			running_out_q   <= running_d;
		end
	end

	assign result_valid     = result_valid_q;
	assign heater_on        = heater_q;
	assign cooler_on        = cooler_q;
	assign display_on       = display_q;
	assign display_value    = display_value_q;
	assign mean_temperature = mean_out_q;
	assign is_running       = running_out_q;

endmodule
